// ===== rtl/bsbr_pkg.sv =====
package bsbr_pkg;

  localparam int MAX_DEGREE = 15;
  localparam int FRAC_IN    = 24;
  localparam int W_W        = 32;
  localparam int W_DEPTH    = MAX_DEGREE + 2;
  localparam int AW         = $clog2(W_DEPTH);
  localparam int RW         = 29;
  localparam int RECIP_N    = 40;
  localparam int RIW        = $clog2(RECIP_N);
  localparam logic [W_W-1:0] ONE_W = 32'h4000_0000;
  localparam logic [63:0]    RONE  = 64'd268435456;

  // Q.28 reciprocals of the step number, rounded
  localparam logic [RW-1:0] RECIP_TAB [RECIP_N] = '{
    29'd0,
    29'((RONE + 0) / 1),   29'((RONE + 1) / 2),   29'((RONE + 1) / 3),
    29'((RONE + 2) / 4),   29'((RONE + 2) / 5),   29'((RONE + 3) / 6),
    29'((RONE + 3) / 7),   29'((RONE + 4) / 8),   29'((RONE + 4) / 9),
    29'((RONE + 5) / 10),  29'((RONE + 5) / 11),  29'((RONE + 6) / 12),
    29'((RONE + 6) / 13),  29'((RONE + 7) / 14),  29'((RONE + 7) / 15),
    29'((RONE + 8) / 16),  29'((RONE + 8) / 17),  29'((RONE + 9) / 18),
    29'((RONE + 9) / 19),  29'((RONE + 10) / 20), 29'((RONE + 10) / 21),
    29'((RONE + 11) / 22), 29'((RONE + 11) / 23), 29'((RONE + 12) / 24),
    29'((RONE + 12) / 25), 29'((RONE + 13) / 26), 29'((RONE + 13) / 27),
    29'((RONE + 14) / 28), 29'((RONE + 14) / 29), 29'((RONE + 15) / 30),
    29'((RONE + 15) / 31), 29'((RONE + 16) / 32), 29'((RONE + 16) / 33),
    29'((RONE + 17) / 34), 29'((RONE + 17) / 35), 29'((RONE + 18) / 36),
    29'((RONE + 18) / 37), 29'((RONE + 19) / 38), 29'((RONE + 19) / 39)
  };

  typedef enum logic [1:0] {WS_ZERO, WS_ONE, WS_PROD} wsel_t;
  typedef enum logic [1:0] {MUL_B, MUL_A, MUL_R} msel_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_CLR, ST_SA, ST_SB, ST_SC,
    ST_RA, ST_RB, ST_MA, ST_MR, ST_WR, ST_FA, ST_FB
  } state_t;

  typedef struct packed {
    logic          load;
    logic          mem_we;
    wsel_t         wsel;
    logic          mem_re;
    logic [AW-1:0] addr;
    msel_t         msel;
    logic          acc_en;
    logic [3:0]    i;
    logic [3:0]    j;
    logic          sl_min_cap;
    logic          sl_cap;
    logic          out_fire;
    logic          out_oor;
  } cmd_t;

  typedef struct packed {
    logic       in_range;
    logic [3:0] k;
    logic [3:0] deg;
  } sts_t;

endpackage

// ===== rtl/bsbr_dpath.sv =====
module bsbr_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [3:0]          cfg_degree,
  input  logic [31:0]         in_position,
  input  bsbr_pkg::cmd_t      cmd,
  output bsbr_pkg::sts_t      sts,
  output logic                out_valid,
  output logic [30:0]         out_basis_value,
  output logic signed [31:0]  out_basis_slope,
  output logic                out_in_range
);

  logic [3:0]                    deg_r;
  logic [31:0]                   pos_r;
  logic [bsbr_pkg::W_W-1:0]      wmem [bsbr_pkg::W_DEPTH];
  logic [bsbr_pkg::W_W-1:0]      rd_r;
  logic [67:0]                   acc_r;
  logic [bsbr_pkg::W_W-1:0]      sl_min_r;
  logic signed [32:0]            slope_r;
  logic                          out_valid_r;
  logic [30:0]                   val_r;
  logic signed [31:0]            slp_r;
  logic                          rng_r;

  logic signed [8:0]             nhi;
  logic [23:0]                   frac;
  logic [27:0]                   op_a;
  logic [28:0]                   op_b;
  logic [67:0]                   rsum_t;
  logic [67:0]                   rsum_w;
  logic [35:0]                   mul_x;
  logic [31:0]                   mul_y;
  logic [67:0]                   prod;
  logic [bsbr_pkg::W_W-1:0]      wdata;
  logic [30:0]                   val_c;
  logic signed [31:0]            slp_c;

  // degree register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r <= 4'd3;
    end else if (cfg_valid) begin
      deg_r <= cfg_degree;
    end
  end

  // segment index and support check
  assign nhi  = -$signed({pos_r[31], pos_r[31:24]});
  assign frac = pos_r[23:0];
  assign sts.deg = deg_r;
  assign sts.k   = nhi[3:0];
  assign sts.in_range = !nhi[8] && (nhi <= $signed({5'd0, deg_r}))
                        && (int'(deg_r) <= bsbr_pkg::MAX_DEGREE);

  // recurrence weights
  assign op_a = {cmd.i - cmd.j, frac};
  assign op_b = {5'({1'b0, cmd.j}) + 5'd1, 24'd0} - {5'd0, frac};

  // rounding of the accumulator
  assign rsum_t = acc_r + 68'(1 << 23);
  assign rsum_w = acc_r + 68'(1 << 27);
  assign wdata  = rsum_w[59:28];

  // shared multiplier
  always_comb begin
    case (cmd.msel)
      bsbr_pkg::MUL_B: begin
        mul_x = {7'd0, op_b};
        mul_y = rd_r;
      end
      bsbr_pkg::MUL_A: begin
        mul_x = {8'd0, op_a};
        mul_y = rd_r;
      end
      default: begin
        mul_x = rsum_t[59:24];
        mul_y = {3'd0, bsbr_pkg::RECIP_TAB[bsbr_pkg::RIW'(cmd.i)]};
      end
    endcase
  end
  assign prod = {32'd0, mul_x} * {36'd0, mul_y};

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      acc_r <= (cmd.msel == bsbr_pkg::MUL_A) ? acc_r + prod : prod;
    end
  end

  // working value store
  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      case (cmd.wsel)
        bsbr_pkg::WS_ONE:  wmem[cmd.addr] <= bsbr_pkg::ONE_W;
        bsbr_pkg::WS_PROD: wmem[cmd.addr] <= wdata;
        default:           wmem[cmd.addr] <= '0;
      endcase
    end
    if (cmd.mem_re) begin
      rd_r <= wmem[cmd.addr];
    end
  end

  // item capture and slope
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r   <= in_position;
      slope_r <= '0;
    end else if (cmd.sl_cap) begin
      slope_r <= $signed({1'b0, sl_min_r}) - $signed({1'b0, rd_r});
    end
    if (cmd.sl_min_cap) begin
      sl_min_r <= rd_r;
    end
  end

  // clamps
  assign val_c = (rd_r > bsbr_pkg::ONE_W) ? 31'(bsbr_pkg::ONE_W) : rd_r[30:0];
  always_comb begin
    if (slope_r > $signed({1'b0, bsbr_pkg::ONE_W})) begin
      slp_c = $signed(bsbr_pkg::ONE_W);
    end else if (slope_r < -$signed({1'b0, bsbr_pkg::ONE_W})) begin
      slp_c = -$signed(bsbr_pkg::ONE_W);
    end else begin
      slp_c = slope_r[31:0];
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_fire | cmd.out_oor;
    end
    if (cmd.out_fire) begin
      val_r <= val_c;
      slp_r <= slp_c;
      rng_r <= 1'b1;
    end else if (cmd.out_oor) begin
      val_r <= '0;
      slp_r <= '0;
      rng_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_basis_value = val_r;
  assign out_basis_slope = slp_r;
  assign out_in_range    = rng_r;

endmodule

// ===== rtl/bsbr_ctrl.sv =====
module bsbr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  bsbr_pkg::sts_t  sts,
  output logic            busy,
  output bsbr_pkg::cmd_t  cmd
);

  bsbr_pkg::state_t          state_r, state_nxt;
  logic [3:0]                i_r, i_nxt;
  logic [3:0]                j_r, j_nxt;
  logic [bsbr_pkg::AW-1:0]   clr_r, clr_nxt;
  logic signed [5:0]         lo_s;
  logic [3:0]                jmin;
  logic [3:0]                i_inc;

  function automatic logic [3:0] jmax_of(input logic [3:0] ii, input logic [3:0] kk);
    jmax_of = (kk < ii) ? kk : ii;
  endfunction

  assign lo_s  = $signed({2'b0, sts.k}) + $signed({2'b0, i_r}) - $signed({2'b0, sts.deg});
  assign jmin  = (lo_s > 0) ? lo_s[3:0] : 4'd0;
  assign i_inc = i_r + 4'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsbr_pkg::ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // next state and loop counters
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      bsbr_pkg::ST_IDLE: if (start) state_nxt = bsbr_pkg::ST_LOAD;
      bsbr_pkg::ST_LOAD: begin
        clr_nxt   = '0;
        state_nxt = sts.in_range ? bsbr_pkg::ST_CLR : bsbr_pkg::ST_IDLE;
      end
      bsbr_pkg::ST_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == bsbr_pkg::AW'(bsbr_pkg::W_DEPTH - 1)) begin
          i_nxt = 4'd1;
          j_nxt = jmax_of(4'd1, sts.k);
          if (sts.deg == 4'd0) begin
            state_nxt = bsbr_pkg::ST_FA;
          end else if (sts.deg == 4'd1) begin
            state_nxt = bsbr_pkg::ST_SA;
          end else begin
            state_nxt = bsbr_pkg::ST_RA;
          end
        end
      end
      bsbr_pkg::ST_SA: state_nxt = bsbr_pkg::ST_SB;
      bsbr_pkg::ST_SB: state_nxt = bsbr_pkg::ST_SC;
      bsbr_pkg::ST_SC: state_nxt = bsbr_pkg::ST_RA;
      bsbr_pkg::ST_RA: state_nxt = bsbr_pkg::ST_RB;
      bsbr_pkg::ST_RB: state_nxt = bsbr_pkg::ST_MA;
      bsbr_pkg::ST_MA: state_nxt = bsbr_pkg::ST_MR;
      bsbr_pkg::ST_MR: state_nxt = bsbr_pkg::ST_WR;
      bsbr_pkg::ST_WR: begin
        if (j_r == jmin) begin
          if (i_r == sts.deg) begin
            state_nxt = bsbr_pkg::ST_FA;
          end else begin
            i_nxt     = i_inc;
            j_nxt     = jmax_of(i_inc, sts.k);
            state_nxt = (i_inc == sts.deg) ? bsbr_pkg::ST_SA : bsbr_pkg::ST_RA;
          end
        end else begin
          j_nxt     = j_r - 4'd1;
          state_nxt = bsbr_pkg::ST_RA;
        end
      end
      bsbr_pkg::ST_FA: state_nxt = bsbr_pkg::ST_FB;
      bsbr_pkg::ST_FB: state_nxt = bsbr_pkg::ST_IDLE;
      default:         state_nxt = bsbr_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd            = '0;
    cmd.wsel       = bsbr_pkg::WS_ZERO;
    cmd.msel       = bsbr_pkg::MUL_B;
    cmd.i          = i_r;
    cmd.j          = j_r;
    unique case (state_r)
      bsbr_pkg::ST_IDLE: cmd.load = start;
      bsbr_pkg::ST_LOAD: cmd.out_oor = !sts.in_range;
      bsbr_pkg::ST_CLR: begin
        cmd.mem_we = 1'b1;
        cmd.addr   = clr_r;
        cmd.wsel   = (clr_r == bsbr_pkg::AW'(1)) ? bsbr_pkg::WS_ONE : bsbr_pkg::WS_ZERO;
      end
      bsbr_pkg::ST_SA: begin
        cmd.mem_re = 1'b1;
        cmd.addr   = bsbr_pkg::AW'(sts.k);
      end
      bsbr_pkg::ST_SB: begin
        cmd.mem_re     = 1'b1;
        cmd.addr       = bsbr_pkg::AW'(sts.k) + 1'b1;
        cmd.sl_min_cap = 1'b1;
      end
      bsbr_pkg::ST_SC: cmd.sl_cap = 1'b1;
      bsbr_pkg::ST_RA: begin
        cmd.mem_re = 1'b1;
        cmd.addr   = bsbr_pkg::AW'(j_r) + 1'b1;
      end
      bsbr_pkg::ST_RB: begin
        cmd.mem_re = 1'b1;
        cmd.addr   = bsbr_pkg::AW'(j_r);
        cmd.msel   = bsbr_pkg::MUL_B;
        cmd.acc_en = 1'b1;
      end
      bsbr_pkg::ST_MA: begin
        cmd.msel   = bsbr_pkg::MUL_A;
        cmd.acc_en = 1'b1;
      end
      bsbr_pkg::ST_MR: begin
        cmd.msel   = bsbr_pkg::MUL_R;
        cmd.acc_en = 1'b1;
      end
      bsbr_pkg::ST_WR: begin
        cmd.mem_we = 1'b1;
        cmd.wsel   = bsbr_pkg::WS_PROD;
        cmd.addr   = bsbr_pkg::AW'(j_r) + 1'b1;
      end
      bsbr_pkg::ST_FA: begin
        cmd.mem_re = 1'b1;
        cmd.addr   = bsbr_pkg::AW'(sts.k) + 1'b1;
      end
      bsbr_pkg::ST_FB: cmd.out_fire = 1'b1;
      default: ;
    endcase
  end

  assign busy = (state_r != bsbr_pkg::ST_IDLE);

endmodule

// ===== rtl/bspline_basis_recurrence_top.sv =====
// Steps per item: load, clear of the 17-entry store, the recurrence updates
//   ((k+1)*(d-k+1)-1 of them, at most 71), slope capture from degree 1, final read;
//   out of support, the load step issues the result. One item at a time, set by
//   the single shared multiplier and the one-port working store.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
// Synchronous active-low reset: controller idle, degree 3, no result pending.
module bspline_basis_recurrence_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_position,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_degree,
  output logic               out_valid,
  output logic [30:0]        out_basis_value,
  output logic signed [31:0] out_basis_slope,
  output logic               out_in_range
);

  bsbr_pkg::cmd_t cmd;
  bsbr_pkg::sts_t sts;

  // degree register always writable
  assign cfg_ready = 1'b1;

  bsbr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  bsbr_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_degree      (cfg_degree),
    .in_position     (in_position),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_basis_value (out_basis_value),
    .out_basis_slope (out_basis_slope),
    .out_in_range    (out_in_range)
  );

endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXD = 15;

  typedef struct {
    logic [30:0]        value;
    logic signed [31:0] slope;
    logic               in_range;
  } basis_t;

  // Holds predicted basis results and compares them with what the block strobes out
  class basis_scoreboard;
    basis_t      pending[$];
    int unsigned mismatches;
    int unsigned checked;
    logic [3:0]  degree;

    function new();
      degree = 4'd3;
      mismatches = 0;
      checked = 0;
    endfunction

    // Cox-de Boor recurrence on Q.30 working values
    function basis_t evaluate(logic signed [31:0] pos);
      basis_t      r;
      longint      x;
      longint      slope;
      longint unsigned w[MAXD + 2];
      longint unsigned f, a, b, s, t, rc, v;
      int          d, k, jmax, jmin;
      x = pos;
      d = degree;
      r.value = '0;
      r.slope = '0;
      r.in_range = 1'b0;
      slope = 0;
      if (d > MAXD || x >= (64'sd1 <<< 24) || x < -(longint'(d) <<< 24)) return r;
      k = (x >= 0) ? 0 : int'((longint'(-x) + (64'sd1 <<< 24) - 1) >>> 24);
      f = longint'(pos) & 64'hFF_FFFF;
      foreach (w[n]) w[n] = 0;
      w[1] = 64'd1 << 30;
      for (int i = 1; i <= d; i++) begin
        jmax = (k < i) ? k : i;
        jmin = (k + i - d > 0) ? k + i - d : 0;
        rc = ((64'd1 << 28) + i / 2) / i;
        if (i == d) slope = longint'(w[k]) - longint'(w[k + 1]);
        for (int j = jmax; j >= jmin; j--) begin
          a = (longint'(i - j) << 24) + f;
          b = (longint'(1 + j) << 24) - f;
          s = a * w[j] + b * w[j + 1];
          t = (s + (64'd1 << 23)) >> 24;
          w[j + 1] = (t * rc + (64'd1 << 27)) >> 28;
        end
      end
      v = w[k + 1];
      if (v > (64'd1 << 30)) v = 64'd1 << 30;
      if (slope > (64'sd1 <<< 30)) slope = 64'sd1 <<< 30;
      if (slope < -(64'sd1 <<< 30)) slope = -(64'sd1 <<< 30);
      r.value = v[30:0];
      r.slope = slope[31:0];
      r.in_range = 1'b1;
      return r;
    endfunction

    function void note_item(logic signed [31:0] pos);
      pending.push_back(evaluate(pos));
    endfunction

    function void check_result(logic [30:0] v, logic signed [31:0] sl, logic ir);
      basis_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result value=%h slope=%h", v, sl);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.value !== v || e.slope !== sl || e.in_range !== ir) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp value=%h slope=%h rng=%b, got value=%h slope=%h rng=%b",
                   e.value, e.slope, e.in_range, v, sl, ir);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_position;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [3:0]         cfg_degree;
  logic               out_valid;
  logic [30:0]        out_basis_value;
  logic signed [31:0] out_basis_slope;
  logic               out_in_range;

  basis_scoreboard sb;

  bspline_basis_recurrence_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_position(in_position),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_degree(cfg_degree),
    .out_valid(out_valid), .out_basis_value(out_basis_value),
    .out_basis_slope(out_basis_slope), .out_in_range(out_in_range)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Results cannot be held off, so take every strobe
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_basis_value, out_basis_slope, out_in_range);
  end

  // Send one position; waits out the given gap first
  task automatic send_position(logic signed [31:0] pos, int gap);
    repeat (gap) @(posedge clk);
    start <= 1'b1;
    in_position <= pos;
    do @(posedge clk); while (busy);
    sb.note_item(pos);
    start <= 1'b0;
    // block is busy for this cycle anyway
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_degree(logic [3:0] d);
    drain();
    cfg_valid <= 1'b1;
    cfg_degree <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.degree = d;
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
  endfunction

  // Mostly positions inside the support, with random fraction
  function automatic logic signed [31:0] pick_position(int d);
    logic signed [31:0] p;
    case ($urandom_range(0, 9))
      0: p = $urandom;
      1: p = ($urandom_range(0, 1) ? (32'sd1 <<< 24) : -(32'sd1 <<< 24) * (d + 1))
             + $urandom_range(0, 3) - 1;
      2: p = -(32'sd1 <<< 24) * $urandom_range(0, d) + $urandom_range(0, 1);
      default: p = -(32'sd1 <<< 24) * $urandom_range(0, d) + {8'd0, 24'($urandom)};
    endcase
    return p;
  endfunction

  initial begin
    int degs[$];
    int d;
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_position = '0;
    cfg_valid = 1'b0;
    cfg_degree = 4'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset degree, bounds of the support and field extremes
    send_position(32'sh7FFF_FFFF, 0);
    send_position(32'sh8000_0000, 0);
    send_position(32'sd0, 1);
    send_position(32'sh00FF_FFFF, 0);
    send_position(32'sh0100_0000, 0);
    send_position(-(32'sd3 <<< 24), 2);
    send_position(-(32'sd3 <<< 24) - 1, 0);
    send_position(-(32'sd1 <<< 24), 0);
    send_position(-(32'sd3 <<< 23), 0);
    send_position(32'shFFFF_FFFF, 0);
    // Degree zero and the largest degree
    set_degree(4'd0);
    send_position(32'sd0, 0);
    send_position(32'sh00FF_FFFF, 0);
    send_position(32'shFFFF_FFFF, 0);
    set_degree(4'd15);
    send_position(-(32'sd15 <<< 24), 0);
    send_position(-(32'sd15 <<< 24) - 1, 0);
    send_position(-(32'sd15 <<< 23), 0);
    send_position(32'sh00FF_FFFF, 0);
    send_position(32'sh5555_5555, 0);
    send_position(32'shAAAA_AAAA, 0);

    // Random phases over many degrees; small ones dominate
    degs = '{1, 2, 4, 15, 0, 3, 5, 7, 1, 2, 9, 12, 15, 3, 6, 11, 2, 8, 0, 4};
    foreach (degs[n]) begin
      set_degree(degs[n][3:0]);
      d = degs[n];
      for (int m = 0; m < ((d > 9) ? 40 : 110); m++) begin
        if (m == 30) drain();
        send_position(pick_position(d), pick_gap());
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
